### rtl/jts_pkg.sv
// Shared types, token kind codes and keyword tables for the JSON token scanner.
package jts_pkg;

	typedef enum logic [3:0] {
		KIND_LBRACE   = 4'd0,
		KIND_RBRACE   = 4'd1,
		KIND_LBRACKET = 4'd2,
		KIND_RBRACKET = 4'd3,
		KIND_COLON    = 4'd4,
		KIND_COMMA    = 4'd5,
		KIND_TRUE     = 4'd6,
		KIND_FALSE    = 4'd7,
		KIND_NULL     = 4'd8,
		KIND_STRING   = 4'd9,
		KIND_INT      = 4'd10,
		KIND_DOUBLE   = 4'd11,
		KIND_ERROR    = 4'd12,
		KIND_END      = 4'd13
	} kind_t;

	// kind field of a result that carries a value character
	localparam logic [3:0] KIND_NONE = 4'd0;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture the incoming byte
		logic step;   // commit one processing step of the held byte
		logic flush;  // keyword error flush in progress
	} jts_cmd_t;

	// datapath -> controller, describes the step pending on the held byte
	typedef struct packed {
		logic emit;        // step produces a result
		logic done;        // step finishes the held byte
		logic flush_next;  // more keyword errors follow
	} jts_status_t;

	function automatic logic [2:0] kw_len(input logic [1:0] id);
		case (id)
			KW_FALSE: kw_len = 3'd5;
			default:  kw_len = 3'd4;
		endcase
	endfunction

	function automatic logic [3:0] kw_kind(input logic [1:0] id);
		case (id)
			KW_TRUE:  kw_kind = KIND_TRUE;
			KW_FALSE: kw_kind = KIND_FALSE;
			default:  kw_kind = KIND_NULL;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] idx);
		logic [39:0] word;
		case (id)
			KW_TRUE:  word = {"true", 8'h00};
			KW_FALSE: word = "false";
			default:  word = {"null", 8'h00};
		endcase
		case (idx)
			3'd0:    kw_char = word[39:32];
			3'd1:    kw_char = word[31:24];
			3'd2:    kw_char = word[23:16];
			3'd3:    kw_char = word[15:8];
			3'd4:    kw_char = word[7:0];
			default: kw_char = 8'h00;
		endcase
	endfunction

endpackage

### rtl/jts_if.sv
// Valid/ready channel interfaces: text bytes in, token results out.
interface jts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface jts_token_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic       token_done;
	logic       char_valid;
	logic [7:0] value_char;
	logic       last;

	modport source (output valid, output token_kind, output token_done, output char_valid,
		output value_char, output last, input ready);
	modport sink (input valid, input token_kind, input token_done, input char_valid,
		input value_char, input last, output ready);
endinterface

### rtl/jts_dp.sv
// Scanner datapath: held byte, scan state, step decode and output result register.
module jts_dp
	import jts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  jts_cmd_t    cmd,
	input  logic [7:0]  text_byte,
	output jts_status_t st,
	output logic [3:0]  token_kind,
	output logic        token_done,
	output logic        char_valid,
	output logic [7:0]  value_char,
	output logic        last
);

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_KEYWORD = 2'd1,
		MODE_STRING  = 2'd2,
		MODE_NUMBER  = 2'd3
	} mode_t;

	logic [7:0] byte_q;
	mode_t      mode_q;
	logic [1:0] kwid_q;
	logic [2:0] kwm_q;
	logic       frac_q;

	logic [3:0] token_kind_q;
	logic       token_done_q;
	logic       char_valid_q;
	logic [7:0] value_char_q;
	logic       last_q;

	// decode of the held byte as seen between tokens
	logic       idle_emit;
	logic [3:0] idle_kind;
	logic       idle_cv;
	mode_t      idle_mode;
	logic [1:0] idle_kwid;
	logic [2:0] idle_kwm;
	logic       idle_frac;

	// pending step
	logic       emit;
	logic       done;
	logic       flush_next;
	logic [3:0] kind;
	logic       cv;
	logic       res_last;
	mode_t      mode_d;
	logic [1:0] kwid_d;
	logic [2:0] kwm_d;
	logic       frac_d;

	logic [2:0] kwm_inc;
	logic       kw_match;
	logic       num_char;

	assign kwm_inc  = kwm_q + 3'd1;
	assign kw_match = (kwm_q < kw_len(kwid_q)) && (byte_q == kw_char(kwid_q, kwm_q));
	assign num_char = byte_q inside {["0":"9"], ".", "e", "E", "+", "-"};

	always_comb begin
		idle_emit = 1'b1;
		idle_kind = KIND_ERROR;
		idle_cv   = 1'b0;
		idle_mode = MODE_IDLE;
		idle_kwid = kwid_q;
		idle_kwm  = 3'd0;
		idle_frac = frac_q;
		case (byte_q) inside
			8'h00: idle_kind = KIND_END;
			8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: idle_emit = 1'b0;
			"{": idle_kind = KIND_LBRACE;
			"}": idle_kind = KIND_RBRACE;
			"[": idle_kind = KIND_LBRACKET;
			"]": idle_kind = KIND_RBRACKET;
			":": idle_kind = KIND_COLON;
			",": idle_kind = KIND_COMMA;
			"t", "f", "n": begin
				idle_emit = 1'b0;
				idle_mode = MODE_KEYWORD;
				idle_kwm  = 3'd1;
				idle_kwid = (byte_q == "t") ? KW_TRUE : ((byte_q == "f") ? KW_FALSE : KW_NULL);
			end
			8'h22: begin
				idle_emit = 1'b0;
				idle_mode = MODE_STRING;
			end
			["0":"9"], "-": begin
				idle_kind = KIND_NONE;
				idle_cv   = 1'b1;
				idle_mode = MODE_NUMBER;
				idle_frac = 1'b0;
			end
			default: idle_kind = KIND_ERROR;
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		done       = 1'b1;
		flush_next = 1'b0;
		kind       = KIND_NONE;
		cv         = 1'b0;
		res_last   = 1'b0;
		mode_d     = mode_q;
		kwid_d     = kwid_q;
		kwm_d      = kwm_q;
		frac_d     = frac_q;
		case (mode_q)
			MODE_KEYWORD: begin
				if (!cmd.flush && kw_match) begin
					if (kwm_inc == kw_len(kwid_q)) begin
						emit     = 1'b1;
						kind     = kw_kind(kwid_q);
						res_last = 1'b1;
						mode_d   = MODE_IDLE;
						kwm_d    = 3'd0;
					end else begin
						kwm_d = kwm_inc;
					end
				end else begin
					// one error per keyword byte taken, then redo this byte from idle
					emit  = 1'b1;
					kind  = KIND_ERROR;
					done  = 1'b0;
					kwm_d = kwm_q - 3'd1;
					if (kwm_q <= 3'd1) begin
						mode_d   = MODE_IDLE;
						kwm_d    = 3'd0;
						res_last = !idle_emit;
					end else begin
						flush_next = 1'b1;
					end
				end
			end
			MODE_STRING: begin
				emit = 1'b1;
				if (byte_q == 8'h22) begin
					kind     = KIND_STRING;
					res_last = 1'b1;
					mode_d   = MODE_IDLE;
				end else if (byte_q == 8'h00) begin
					// error now; the idle pass over the same byte gives end
					kind   = KIND_ERROR;
					done   = 1'b0;
					mode_d = MODE_IDLE;
				end else begin
					cv       = 1'b1;
					res_last = 1'b1;
				end
			end
			MODE_NUMBER: begin
				emit = 1'b1;
				if (num_char) begin
					cv       = 1'b1;
					res_last = 1'b1;
					if (byte_q == "." || byte_q == "e" || byte_q == "E")
						frac_d = 1'b1;
				end else begin
					kind     = frac_q ? KIND_DOUBLE : KIND_INT;
					done     = 1'b0;
					res_last = !idle_emit;
					mode_d   = MODE_IDLE;
					frac_d   = 1'b0;
				end
			end
			default: begin
				emit     = idle_emit;
				kind     = idle_kind;
				cv       = idle_cv;
				res_last = idle_emit;
				mode_d   = idle_mode;
				kwid_d   = idle_kwid;
				kwm_d    = idle_kwm;
				frac_d   = idle_frac;
			end
		endcase
	end

	assign st.emit       = emit;
	assign st.done       = done;
	assign st.flush_next = flush_next;

	always_ff @(posedge clk) begin
		if (cmd.load)
			byte_q <= text_byte;
		if (cmd.step && emit) begin
			token_kind_q <= kind;
			token_done_q <= !cv;
			char_valid_q <= cv;
			value_char_q <= cv ? byte_q : 8'h00;
			last_q       <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			kwid_q <= KW_TRUE;
			kwm_q  <= 3'd0;
			frac_q <= 1'b0;
		end else if (cmd.step) begin
			mode_q <= mode_d;
			kwid_q <= kwid_d;
			kwm_q  <= kwm_d;
			frac_q <= frac_d;
		end
	end

	assign token_kind = token_kind_q;
	assign token_done = token_done_q;
	assign char_valid = char_valid_q;
	assign value_char = value_char_q;
	assign last       = last_q;

endmodule

### rtl/jts_ctrl.sv
// Scanner controller: byte holding, keyword error flush and output register occupancy.
module jts_ctrl
	import jts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  jts_status_t st,
	output jts_cmd_t    cmd
);

	typedef enum logic [1:0] {
		C_EMPTY = 2'd0,
		C_HOLD  = 2'd1,
		C_FLUSH = 2'd2
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        out_valid_d;
	logic        out_free;
	logic        advance;
	logic        load;

	assign out_free = !out_valid_q || out_ready;
	// a step that produces no result never waits on the output side
	assign advance  = (state_q != C_EMPTY) && (!st.emit || out_free);
	assign in_ready = (state_q == C_EMPTY) || (advance && st.done);
	assign load     = in_valid && in_ready;

	assign cmd.load  = load;
	assign cmd.step  = advance;
	assign cmd.flush = (state_q == C_FLUSH);

	always_comb begin
		state_d = state_q;
		if (advance) begin
			if (st.flush_next)
				state_d = C_FLUSH;
			else if (st.done)
				state_d = load ? C_HOLD : C_EMPTY;
			else
				state_d = C_HOLD;
		end else if (state_q == C_EMPTY && load) begin
			state_d = C_HOLD;
		end

		if (advance && st.emit)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_FLUSH |-> !in_ready)
		else $error("byte accepted during keyword error flush");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(cmd.step && st.emit))
		else $error("pending result overwritten");

	a_flush_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_FLUSH && advance && !st.flush_next |=> state_q == C_HOLD)
		else $error("flush did not return to reprocess the held byte");

	a_status_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != C_EMPTY && st.flush_next |-> st.emit && !st.done)
		else $error("flush step must emit an error and keep the byte");

endmodule

### rtl/json_token_scanner.sv
// JSON token scanner: streams text bytes in and emits token and value-character results.
//
// Channel text carries one text byte per transaction; byte 0 ends the text.
// Channel token carries results: structural tokens, keywords, string and number
// characters (char_valid) followed by a closing result with token_done and
// token_kind, errors and end. last marks the final result caused by one byte;
// a byte may cause no result at all (whitespace, opening quote, keyword bytes).
// Throughput: each result that a held byte causes takes its own step, and
// a byte with at most one result leaves room for the next byte in the same
// cycle, so plain text runs at one byte per cycle while the receiver keeps up.
// A keyword that fails after k bytes gives k errors and then redoes the
// failing byte from idle; a number closed by a following byte, or a string
// cut off by end of text, gives its result first, then redoes the byte from idle.
// A byte is held in a register, and its results go to the output register.
// A single output register sits between the scanner and token; when the
// receiver stalls, that register holds and text.ready drops once the next
// result has nowhere to go. Reset clears the scan state to between tokens and
// empties both the held byte and the output register.
module json_token_scanner
	import jts_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	jts_byte_if.sink     text,
	jts_token_if.source  token
);

	jts_cmd_t    cmd;
	jts_status_t st;

	jts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_ready  (text.ready),
		.out_valid (token.valid),
		.out_ready (token.ready),
		.st        (st),
		.cmd       (cmd)
	);

	jts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.text_byte  (text.text_byte),
		.st         (st),
		.token_kind (token.token_kind),
		.token_done (token.token_done),
		.char_valid (token.char_valid),
		.value_char (token.value_char),
		.last       (token.last)
	);

endmodule
